// ===== design/iccl_pkg.sv =====
// Shared types, constants and codes for the edge-clamped image convolution block.
package iccl_pkg;

    // Default sizes of the frame store and the tap table.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_KERNEL_DEF = 7;

    // Weights are signed Q1.15 fixed point.
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = WEIGHT_BITS - 1;

    // Image dimension registers and the kernel side register.
    localparam int DIM_BITS       = 9;
    localparam int KREG_BITS      = 3;
    localparam int KSIZE_BITS     = 4;
    localparam int REG_INDEX_BITS = 2;
    localparam int DIM_RESET      = 256;
    localparam int KSIZE_RESET    = 3;

    // Signed neighbor coordinates before clamping.
    localparam int COORD_BITS = 11;

    // Item actions.
    localparam logic [1:0] ACT_STORE_PIXEL = 2'd0;
    localparam logic [1:0] ACT_STORE_TAP   = 2'd1;
    localparam logic [1:0] ACT_COMPUTE     = 2'd2;

    // Configuration register indexes.
    localparam logic [REG_INDEX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_KSIZE  = 2'd2;

    typedef struct packed {
        logic [1:0]                    action;
        logic [7:0]                    column;
        logic [7:0]                    row;
        logic [7:0]                    pixel_in;
        logic [2:0]                    tap_row;
        logic [2:0]                    tap_col;
        logic signed [WEIGHT_BITS-1:0] tap_weight;
    } iccl_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       clipped;
    } iccl_result_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        logic [KSIZE_BITS-1:0] ksize;
    } iccl_cfg_t;

    typedef struct packed {
        logic accept;
        logic out_free;
    } iccl_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iccl_sts_t;

endpackage

// ===== design/iccl_engine.sv =====
// Frame store, tap table, tap sequencer and multiply-accumulate pipeline.
module iccl_engine #(
    parameter int MAX_WIDTH  = iccl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = iccl_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_KERNEL = iccl_pkg::MAX_KERNEL_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iccl_pkg::iccl_item_t  item,
    input  iccl_pkg::iccl_cfg_t   cfg,
    input  iccl_pkg::iccl_ctl_t   ctl,
    output iccl_pkg::iccl_sts_t   sts,
    output iccl_pkg::iccl_result_t result
);

    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PA_W      = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int TAP_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int TA_W      = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
    localparam int PROD_W    = 8 + 1 + iccl_pkg::WEIGHT_BITS;
    localparam int ACC_W     = PROD_W + TA_W + 1;
    localparam int CW        = iccl_pkg::COORD_BITS;
    localparam int KB        = iccl_pkg::KSIZE_BITS;
    localparam int DB        = iccl_pkg::DIM_BITS;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (iccl_pkg::FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] PIX_MAX  = ACC_W'(255);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [7:0]                             pix_mem [PIX_DEPTH];
    logic signed [iccl_pkg::WEIGHT_BITS-1:0] tap_mem [TAP_DEPTH];

    logic [1:0]            state_reg, state_next;
    logic [KB-1:0]         i_reg, i_next, j_reg, j_next;
    logic signed [CW-1:0]  xb_reg, xb_next, yb_reg, yb_next;
    logic                  rd_vld_reg, mul_vld_reg;

    logic [7:0]                              pix_q_reg;
    logic signed [iccl_pkg::WEIGHT_BITS-1:0] w_q_reg;
    logic signed [PROD_W-1:0]                prod_reg;
    logic signed [ACC_W-1:0]                 acc_reg;

    logic                 start, pix_we, tap_we, last_i, last_j, drain_end, done;
    logic [PA_W-1:0]      pix_waddr, pix_raddr;
    logic [TA_W-1:0]      tap_waddr, tap_raddr;
    logic [KB-1:0]        off;
    logic signed [CW-1:0] x_raw, y_raw, x_max, y_max, x_cl, y_cl;
    logic [DB-1:0]        x_idx, y_idx;
    logic signed [8:0]    pix_s;
    logic signed [PROD_W-1:0] prod_w;
    logic signed [ACC_W-1:0]  rnd, q;

    // Decode of the accepted transaction.
    assign start  = ctl.accept && (item.action == iccl_pkg::ACT_COMPUTE);
    assign pix_we = ctl.accept && (item.action == iccl_pkg::ACT_STORE_PIXEL)
                    && (32'(item.column) < MAX_WIDTH) && (32'(item.row) < MAX_HEIGHT);
    assign tap_we = ctl.accept && (item.action == iccl_pkg::ACT_STORE_TAP)
                    && (32'(item.tap_row) < MAX_KERNEL) && (32'(item.tap_col) < MAX_KERNEL);

    assign pix_waddr = PA_W'(32'(item.row) * MAX_WIDTH + 32'(item.column));
    assign tap_waddr = TA_W'(32'(item.tap_row) * MAX_KERNEL + 32'(item.tap_col));

    assign off = cfg.ksize >> 1;

    // Neighbor coordinates, clamped to the image so the border pixels repeat.
    assign x_raw = xb_reg + $signed(CW'(j_reg));
    assign y_raw = yb_reg + $signed(CW'(i_reg));
    assign x_max = $signed(CW'(cfg.width) - CW'(1));
    assign y_max = $signed(CW'(cfg.height) - CW'(1));

    always_comb
    begin
        if (x_raw < 0)
            x_cl = '0;
        else if (x_raw > x_max)
            x_cl = x_max;
        else
            x_cl = x_raw;
        if (y_raw < 0)
            y_cl = '0;
        else if (y_raw > y_max)
            y_cl = y_max;
        else
            y_cl = y_raw;
    end

    assign x_idx = DB'(x_cl);
    assign y_idx = DB'(y_cl);

    assign pix_raddr = PA_W'(32'(y_idx) * MAX_WIDTH + 32'(x_idx));
    assign tap_raddr = TA_W'(32'(i_reg) * MAX_KERNEL + 32'(j_reg));

    assign last_j = (j_reg == cfg.ksize - KB'(1));
    assign last_i = (i_reg == cfg.ksize - KB'(1));

    // The last product has reached the accumulator once both pipeline stages are empty.
    assign drain_end = (state_reg == S_DRAIN) && !rd_vld_reg && !mul_vld_reg;
    assign done      = drain_end && ctl.out_free;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        xb_next    = xb_reg;
        yb_next    = yb_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    xb_next    = $signed(CW'(item.column)) - $signed(CW'(off));
                    yb_next    = $signed(CW'(item.row)) - $signed(CW'(off));
                end
            end
            S_RUN:
            begin
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                        state_next = S_DRAIN;
                    else
                        i_next = i_reg + KB'(1);
                end
                else
                begin
                    j_next = j_reg + KB'(1);
                end
            end
            S_DRAIN:
            begin
                if (done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            xb_reg      <= '0;
            yb_reg      <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            xb_reg      <= xb_next;
            yb_reg      <= yb_next;
            rd_vld_reg  <= (state_reg == S_RUN);
            mul_vld_reg <= rd_vld_reg;
        end
    end

    // Stores are only taken while no compute is running, so reads and writes never collide.
    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_waddr] <= item.pixel_in;
        if (state_reg == S_RUN)
            pix_q_reg <= pix_mem[pix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tap_we)
            tap_mem[tap_waddr] <= item.tap_weight;
        if (state_reg == S_RUN)
            w_q_reg <= tap_mem[tap_raddr];
    end

    assign pix_s  = $signed({1'b0, pix_q_reg});
    assign prod_w = PROD_W'(pix_s) * PROD_W'(w_q_reg);

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
            prod_reg <= prod_w;
        if (start)
            acc_reg <= '0;
        else if (mul_vld_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Round half up is an add of one half and an arithmetic shift for either sign.
    assign rnd = acc_reg + RND_HALF;
    assign q   = rnd >>> iccl_pkg::FRAC_BITS;

    always_comb
    begin
        if (q < 0)
        begin
            result.pixel_out = 8'd0;
            result.clipped   = 1'b1;
        end
        else if (q > PIX_MAX)
        begin
            result.pixel_out = 8'd255;
            result.clipped   = 1'b1;
        end
        else
        begin
            result.pixel_out = q[7:0];
            result.clipped   = 1'b0;
        end
    end

    assign sts.busy = (state_reg != S_IDLE);
    assign sts.done = done;

endmodule

// ===== design/image_convolution_edge_clamp.sv =====
// Top level of the edge-clamped grayscale image convolution block.
//
// Items arrive on the item channel (item_valid, item_stall, item_data). A store-pixel
// or store-tap transaction writes the frame memory or the tap table without making the
// block busy, so stores can stream at one per clock while no compute holds item_stall.
// A compute transaction reads one pixel and one weight per kernel tap from the two
// memories, one tap per cycle, and multiplies and accumulates them in a two-stage
// pipeline. No further item is taken until the compute result has passed to the
// output register; the frame memory read port, one read per tap, bounds how often
// computes can run.
// Results leave on the result channel (result_valid, result_stall, result_data) from
// an output register. While that register waits on a stalled receiver, further items
// are still accepted; a compute that finishes meanwhile holds its sum until the
// register frees up, keeping item_stall high.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always ready
// and must only be issued while the block is idle. Reset restores a 256x256 image and
// a 3x3 kernel; frame and tap contents are undefined until written.
module image_convolution_edge_clamp #(
    parameter int MAX_WIDTH  = iccl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = iccl_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_KERNEL = iccl_pkg::MAX_KERNEL_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  iccl_pkg::iccl_item_t                  item_data,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output iccl_pkg::iccl_result_t                result_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [iccl_pkg::REG_INDEX_BITS-1:0]   cfg_index,
    input  logic [iccl_pkg::DIM_BITS-1:0]         cfg_data
);

    localparam int DB = iccl_pkg::DIM_BITS;
    localparam int KB = iccl_pkg::KSIZE_BITS;

    localparam int RST_WIDTH  = (MAX_WIDTH < iccl_pkg::DIM_RESET) ? MAX_WIDTH
                                                                  : iccl_pkg::DIM_RESET;
    localparam int RST_HEIGHT = (MAX_HEIGHT < iccl_pkg::DIM_RESET) ? MAX_HEIGHT
                                                                   : iccl_pkg::DIM_RESET;
    localparam int RST_KSIZE  = (MAX_KERNEL < iccl_pkg::KSIZE_RESET) ? MAX_KERNEL
                                                                     : iccl_pkg::KSIZE_RESET;

    iccl_pkg::iccl_cfg_t    cfg_reg, cfg_next;
    iccl_pkg::iccl_ctl_t    ctl;
    iccl_pkg::iccl_sts_t    sts;
    iccl_pkg::iccl_result_t eng_result;
    iccl_pkg::iccl_result_t result_data_reg;
    logic                   result_valid_reg;
    logic                   cfg_we;

    function automatic logic [DB-1:0] sat_dim(input logic [DB-1:0] v, input int hi);
        logic [DB-1:0] r;
        if (v == '0)
            r = DB'(1);
        else if (int'(v) > hi)
            r = DB'(hi);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [KB-1:0] sat_k(input logic [iccl_pkg::KREG_BITS-1:0] v,
                                            input int hi);
        logic [KB-1:0] r;
        if (v == '0)
            r = KB'(1);
        else if (int'(v) > hi)
            r = KB'(hi);
        else
            r = KB'(v);
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                iccl_pkg::REG_WIDTH:  cfg_next.width  = sat_dim(cfg_data, MAX_WIDTH);
                iccl_pkg::REG_HEIGHT: cfg_next.height = sat_dim(cfg_data, MAX_HEIGHT);
                iccl_pkg::REG_KSIZE:
                    cfg_next.ksize = sat_k(cfg_data[iccl_pkg::KREG_BITS-1:0], MAX_KERNEL);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= DB'(RST_WIDTH);
            cfg_reg.height <= DB'(RST_HEIGHT);
            cfg_reg.ksize  <= KB'(RST_KSIZE);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign item_stall   = sts.busy;
    assign ctl.accept   = item_valid && !item_stall;
    assign ctl.out_free = !result_valid_reg || !result_stall;

    iccl_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_data),
        .cfg    (cfg_reg),
        .ctl    (ctl),
        .sts    (sts),
        .result (eng_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (sts.done)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sts.done)
            result_data_reg <= eng_result;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

// ===== design/iccl_checker.sv =====
// Port-level assertions for the edge-clamped image convolution block, bound to its top level.
module iccl_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_stall,
    input iccl_pkg::iccl_item_t   item_data,
    input logic                   result_valid,
    input logic                   result_stall,
    input iccl_pkg::iccl_result_t result_data
);

    // A stalled result stays offered and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed or was dropped");

    // A compute transaction occupies the block in the following cycle.
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item_data.action == iccl_pkg::ACT_COMPUTE)
        |=> item_stall)
        else $error("block not busy after a compute transaction");

    // Stores finish in the cycle they are taken.
    a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall
        && ((item_data.action == iccl_pkg::ACT_STORE_PIXEL)
            || (item_data.action == iccl_pkg::ACT_STORE_TAP))
        |=> !item_stall)
        else $error("store transaction left the block busy");

    // A new result only comes out of a running compute.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result offered without a compute in progress");

endmodule

bind image_convolution_edge_clamp iccl_checker u_iccl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);
